[rtl/cop_pkg.sv]
// Shared types and constants for the coinbase output parser.
// No dependencies; used by the top level and by its checker.
package cop_pkg;

    localparam int REC_CNT_W = 6;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } t_in_item;

    typedef struct packed {
        logic                 record_kind;
        logic [31:0]          output_index;
        logic [63:0]          out_value;
        logic [2:0]           script_kind;
        logic [31:0]          script_length;
        logic [63:0]          total_value;
        logic [REC_CNT_W-1:0] records_counted;
        logic                 parse_status;
        logic                 last_of_run;
    } t_out_item;

    typedef enum logic [8:0] {
        PH_SKIP     = 9'b000000001,
        PH_SEQ      = 9'b000000010,
        PH_CNT      = 9'b000000100,
        PH_CNT_EXT  = 9'b000001000,
        PH_VAL      = 9'b000010000,
        PH_SLEN     = 9'b000100000,
        PH_SLEN_EXT = 9'b001000000,
        PH_SCRIPT   = 9'b010000000,
        PH_DONE     = 9'b100000000
    } t_phase;

    localparam logic REC_OUTPUT  = 1'b0;
    localparam logic REC_SUMMARY = 1'b1;
    localparam logic ST_OK       = 1'b0;
    localparam logic ST_SHORT    = 1'b1;

    localparam logic [2:0] SK_P2PKH   = 3'd0;
    localparam logic [2:0] SK_P2SH    = 3'd1;
    localparam logic [2:0] SK_P2WPKH  = 3'd2;
    localparam logic [2:0] SK_P2WSH   = 3'd3;
    localparam logic [2:0] SK_P2TR    = 3'd4;
    localparam logic [2:0] SK_OPRET   = 3'd5;
    localparam logic [2:0] SK_UNKNOWN = 3'd6;
    localparam logic [2:0] SK_EMPTY   = 3'd7;

    localparam logic [7:0] VARINT_16 = 8'hFD;
    localparam logic [7:0] VARINT_32 = 8'hFE;

    localparam logic [3:0] EXT_LEN_16 = 4'd2;
    localparam logic [3:0] EXT_LEN_32 = 4'd4;
    localparam logic [3:0] EXT_LEN_64 = 4'd8;

    localparam logic [31:0] LEN_P2PKH  = 32'd25;
    localparam logic [31:0] LEN_P2SH   = 32'd23;
    localparam logic [31:0] LEN_P2WPKH = 32'd22;
    localparam logic [31:0] LEN_W32    = 32'd34;

    localparam logic [4:0] POS_TAIL0 = 5'd22;
    localparam logic [4:0] POS_TAIL1 = 5'd23;
    localparam logic [4:0] POS_TAIL2 = 5'd24;
    localparam logic [4:0] POS_SAT   = 5'd25;

    localparam logic [7:0] OP_0         = 8'h00;
    localparam logic [7:0] OP_1         = 8'h51;
    localparam logic [7:0] OP_DUP       = 8'h76;
    localparam logic [7:0] OP_HASH      = 8'hA9;
    localparam logic [7:0] OP_PUSH20    = 8'h14;
    localparam logic [7:0] OP_PUSH32    = 8'h20;
    localparam logic [7:0] OP_RET       = 8'h6A;
    localparam logic [7:0] OP_EQ        = 8'h87;
    localparam logic [7:0] OP_EQ_VERIFY = 8'h88;
    localparam logic [7:0] OP_CHK_SIG   = 8'hAC;

endpackage

[rtl/coinbase_output_parser.sv]
// Coinbase output parser: byte-serial decode of the output section.
// Depends on cop_pkg. One byte per cycle while o_stall is low; results leave through a 4-deep queue.
// A result is written into the queue register with the byte that causes it and leaves from the queue head.
// Throughput: one byte per cycle while o_stall is low; a byte may cause two results.
// Queue takes up to two results per byte, drains one; stall while under two slots free.
// Reset (synchronous): parser state and queue cleared, skip_bytes to 0.
module coinbase_output_parser
    import cop_pkg::*;
#(
    parameter int MAX_RECORDS = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_wr_en,
    input  logic [7:0] i_cfg_wr_data,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_item  i_data,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_data
);

    localparam int RecW = $clog2(MAX_RECORDS + 1);

    t_phase          r_phase, n_phase;
    logic [7:0]      r_cnt, n_cnt;
    logic [4:0]      r_pos, n_pos;
    logic [3:0]      r_left, n_left;
    logic [63:0]     r_varint, n_varint;
    logic [63:0]     r_outs, n_outs;
    logic [31:0]     r_index, n_index;
    logic [63:0]     r_value, n_value;
    logic [31:0]     r_slen, n_slen;
    logic [63:0]     r_remain, n_remain;
    logic [23:0]     r_head, n_head;
    logic [2:0]      r_flags, n_flags;
    logic [63:0]     r_total, n_total;
    logic [RecW-1:0] r_recs, n_recs;
    logic [7:0]      r_skip;

    t_out_item       r_queue [4];
    logic [1:0]      r_wr_ptr, r_rd_ptr;
    logic [2:0]      r_count;

    logic        accept, pop, finish, fin;
    logic [7:0]  b;
    logic        len_known;
    logic [63:0] len_val, byte_lane, varint_next, outs_dec;
    logic [1:0]  push_n, wr_ptr1;
    logic [3:0]  left_dec;
    t_out_item   rec_item, sum_item, first_item;

    function automatic logic [2:0] classify(input logic [31:0] n, input logic [23:0] h,
                                            input logic [2:0] f);
        logic [7:0] h0, h1, h2;
        logic [2:0] k;
        h0 = h[7:0];
        h1 = h[15:8];
        h2 = h[23:16];
        if (n == 32'd0)
            k = SK_EMPTY;
        else if (n == LEN_P2PKH && h0 == OP_DUP && h1 == OP_HASH && h2 == OP_PUSH20
                 && f[1] && f[2])
            k = SK_P2PKH;
        else if (n == LEN_P2SH && h0 == OP_HASH && h1 == OP_PUSH20 && f[0])
            k = SK_P2SH;
        else if (n == LEN_P2WPKH && h0 == OP_0 && h1 == OP_PUSH20)
            k = SK_P2WPKH;
        else if (n == LEN_W32 && h0 == OP_0 && h1 == OP_PUSH32)
            k = SK_P2WSH;
        else if (n == LEN_W32 && h0 == OP_1 && h1 == OP_PUSH32)
            k = SK_P2TR;
        else if (h0 == OP_RET)
            k = SK_OPRET;
        else
            k = SK_UNKNOWN;
        return k;
    endfunction

    function automatic logic [3:0] ext_len(input logic [7:0] v);
        logic [3:0] l;
        case (v)
            VARINT_16: l = EXT_LEN_16;
            VARINT_32: l = EXT_LEN_32;
            default:   l = EXT_LEN_64;
        endcase
        return l;
    endfunction

    assign accept  = i_valid && !o_stall;
    assign pop     = o_valid && !i_stall;
    assign o_stall = (r_count > 3'd2);
    assign o_valid = (r_count != 3'd0);
    assign o_data  = r_queue[r_rd_ptr];
    assign b       = i_data.data_byte;
    assign fin     = accept && i_data.final_byte;

    always_comb begin
        n_phase  = r_phase;
        n_cnt    = r_cnt;
        n_pos    = r_pos;
        n_left   = r_left;
        n_varint = r_varint;
        n_outs   = r_outs;
        n_index  = r_index;
        n_value  = r_value;
        n_slen   = r_slen;
        n_remain = r_remain;
        n_head   = r_head;
        n_flags  = r_flags;
        n_total  = r_total;
        n_recs   = r_recs;
        finish    = 1'b0;
        len_known = 1'b0;
        len_val   = 64'd0;
        outs_dec  = 64'd0;
        left_dec  = 4'd0;
        byte_lane   = 64'(b) << {r_cnt[2:0], 3'b000};
        varint_next = r_varint | byte_lane;
        rec_item    = '0;
        sum_item    = '0;

        if (accept) begin
            case (r_phase)
                PH_SKIP: begin
                    if (r_cnt < r_skip) begin
                        n_cnt = r_cnt + 8'd1;
                    end else begin
                        // this byte is the first sequence byte
                        n_phase = PH_SEQ;
                        n_cnt   = 8'd1;
                    end
                end
                PH_SEQ: begin
                    if (r_cnt >= 8'd3) begin
                        n_phase = PH_CNT;
                        n_cnt   = 8'd0;
                    end else begin
                        n_cnt = r_cnt + 8'd1;
                    end
                end
                PH_CNT: begin
                    if (b < VARINT_16) begin
                        n_outs  = 64'(b);
                        n_index = 32'd0;
                        if (b == 8'd0) begin
                            n_phase = PH_DONE;
                        end else begin
                            n_phase = PH_VAL;
                            n_cnt   = 8'd0;
                            n_value = 64'd0;
                        end
                    end else begin
                        n_left   = ext_len(b);
                        n_varint = 64'd0;
                        n_cnt    = 8'd0;
                        n_phase  = PH_CNT_EXT;
                    end
                end
                PH_SLEN: begin
                    if (b < VARINT_16) begin
                        len_known = 1'b1;
                        len_val   = 64'(b);
                    end else begin
                        n_left   = ext_len(b);
                        n_varint = 64'd0;
                        n_cnt    = 8'd0;
                        n_phase  = PH_SLEN_EXT;
                    end
                end
                PH_CNT_EXT, PH_SLEN_EXT: begin
                    if (r_cnt < 8'd8)
                        n_varint = varint_next;
                    n_cnt    = r_cnt + 8'd1;
                    left_dec = (r_left != 4'd0) ? r_left - 4'd1 : 4'd0;
                    n_left   = left_dec;
                    if (left_dec == 4'd0) begin
                        if (r_phase == PH_CNT_EXT) begin
                            n_outs  = n_varint;
                            n_index = 32'd0;
                            if (n_varint == 64'd0) begin
                                n_phase = PH_DONE;
                            end else begin
                                n_phase = PH_VAL;
                                n_cnt   = 8'd0;
                                n_value = 64'd0;
                            end
                        end else begin
                            len_known = 1'b1;
                            len_val   = n_varint;
                        end
                    end
                end
                PH_VAL: begin
                    n_value = r_value | byte_lane;
                    if (r_cnt >= 8'd7) begin
                        n_phase = PH_SLEN;
                        n_cnt   = 8'd0;
                    end else begin
                        n_cnt = r_cnt + 8'd1;
                    end
                end
                PH_SCRIPT: begin
                    if (r_pos < 5'd3) begin
                        n_head = r_head | (24'(b) << {r_pos[1:0], 3'b000});
                    end else if (r_pos == POS_TAIL0 && b == OP_EQ) begin
                        n_flags = r_flags | 3'b001;
                    end else if (r_pos == POS_TAIL1 && b == OP_EQ_VERIFY) begin
                        n_flags = r_flags | 3'b010;
                    end else if (r_pos == POS_TAIL2 && b == OP_CHK_SIG) begin
                        n_flags = r_flags | 3'b100;
                    end
                    if (r_pos != POS_SAT)
                        n_pos = r_pos + 5'd1;
                    if (r_remain == 64'd1)
                        finish = 1'b1;
                    else
                        n_remain = r_remain - 64'd1;
                end
                default: begin
                end
            endcase

            if (len_known) begin
                n_slen   = (len_val[63:32] != 32'd0) ? 32'hFFFF_FFFF : len_val[31:0];
                n_head   = 24'd0;
                n_flags  = 3'd0;
                n_cnt    = 8'd0;
                n_pos    = 5'd0;
                n_remain = len_val;
                if (len_val == 64'd0)
                    finish = 1'b1;
                else
                    n_phase = PH_SCRIPT;
            end

            if (finish) begin
                n_total = r_total + r_value;
                if (r_recs < RecW'(MAX_RECORDS))
                    n_recs = r_recs + RecW'(1);
                rec_item.record_kind     = REC_OUTPUT;
                rec_item.output_index    = r_index;
                rec_item.out_value       = r_value;
                rec_item.script_kind     = classify(n_slen, n_head, n_flags);
                rec_item.script_length   = n_slen;
                rec_item.total_value     = n_total;
                rec_item.records_counted = REC_CNT_W'(n_recs);
                rec_item.parse_status    = ST_OK;
                rec_item.last_of_run     = !i_data.final_byte;
                if (r_index != 32'hFFFF_FFFF)
                    n_index = r_index + 32'd1;
                outs_dec = r_outs - 64'd1;
                n_outs   = outs_dec;
                if (outs_dec == 64'd0) begin
                    n_phase = PH_DONE;
                end else begin
                    n_phase = PH_VAL;
                    n_cnt   = 8'd0;
                    n_value = 64'd0;
                end
            end

            if (fin) begin
                sum_item.record_kind     = REC_SUMMARY;
                sum_item.output_index    = n_index;
                sum_item.total_value     = n_total;
                sum_item.records_counted = REC_CNT_W'(n_recs);
                sum_item.parse_status    = (n_phase inside {PH_SKIP, PH_SEQ, PH_CNT,
                                                            PH_CNT_EXT}) ? ST_SHORT : ST_OK;
                sum_item.last_of_run     = 1'b1;
                n_phase  = PH_SKIP;
                n_cnt    = 8'd0;
                n_pos    = 5'd0;
                n_left   = 4'd0;
                n_varint = 64'd0;
                n_outs   = 64'd0;
                n_index  = 32'd0;
                n_value  = 64'd0;
                n_slen   = 32'd0;
                n_remain = 64'd0;
                n_head   = 24'd0;
                n_flags  = 3'd0;
                n_total  = 64'd0;
                n_recs   = '0;
            end
        end
    end

    assign push_n     = {1'b0, finish} + {1'b0, fin};
    assign wr_ptr1    = r_wr_ptr + 2'd1;
    assign first_item = finish ? rec_item : sum_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_SKIP;
            r_cnt    <= 8'd0;
            r_pos    <= 5'd0;
            r_left   <= 4'd0;
            r_varint <= 64'd0;
            r_outs   <= 64'd0;
            r_index  <= 32'd0;
            r_value  <= 64'd0;
            r_slen   <= 32'd0;
            r_remain <= 64'd0;
            r_head   <= 24'd0;
            r_flags  <= 3'd0;
            r_total  <= 64'd0;
            r_recs   <= '0;
            r_skip   <= 8'd0;
            r_wr_ptr <= 2'd0;
            r_rd_ptr <= 2'd0;
            r_count  <= 3'd0;
        end else begin
            r_phase  <= n_phase;
            r_cnt    <= n_cnt;
            r_pos    <= n_pos;
            r_left   <= n_left;
            r_varint <= n_varint;
            r_outs   <= n_outs;
            r_index  <= n_index;
            r_value  <= n_value;
            r_slen   <= n_slen;
            r_remain <= n_remain;
            r_head   <= n_head;
            r_flags  <= n_flags;
            r_total  <= n_total;
            r_recs   <= n_recs;
            if (i_cfg_wr_en)
                r_skip <= i_cfg_wr_data;
            r_wr_ptr <= r_wr_ptr + push_n;
            if (pop)
                r_rd_ptr <= r_rd_ptr + 2'd1;
            r_count  <= r_count + {1'b0, push_n} - {2'b00, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_n != 2'd0)
            r_queue[r_wr_ptr] <= first_item;
        if (push_n == 2'd2)
            r_queue[wr_ptr1] <= sum_item;
    end

endmodule

[rtl/cop_checker.sv]
// Port-level checks for the coinbase output parser, bound to the top level.
// Depends on cop_pkg and on coinbase_output_parser.
module cop_checker
    import cop_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_valid,
    input logic      i_stall,
    input t_out_item o_data
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("result changed while stalled");

    a_summary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.record_kind == REC_SUMMARY |->
            o_data.out_value == 64'd0 && o_data.script_kind == SK_P2PKH
            && o_data.script_length == 32'd0 && o_data.last_of_run)
        else $error("malformed summary");

    a_rec_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.record_kind == REC_OUTPUT |-> o_data.parse_status == ST_OK)
        else $error("output record with error status");

    a_followed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_data.last_of_run |=> o_valid)
        else $error("summary missing after record");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result shown after reset");

endmodule

bind coinbase_output_parser cop_checker u_cop_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_data  (o_data)
);
